// ===== hdl/mwi_pkg.sv =====
// Shared types and constants for the mipmapped wavetable interpolator.
package mwi_pkg;

    // Default number of index bits of the largest level (level 0)
    localparam int unsigned TABLE_BITS_DEF = 10;

    // Fixed field widths
    localparam int unsigned LEVEL_W  = 4;
    localparam int unsigned WIDX_W   = 10;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned PHASE_W  = 32;
    localparam int unsigned FRAC_W   = 16;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Registered read data handed from the store to the interpolator
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] si;
        logic signed [SAMPLE_W-1:0] sj;
        logic        [FRAC_W-1:0]   frac;
    } t_rd_data;

endpackage

// ===== hdl/mwi_store.sv =====
// Level address decode and dual-read sample memory for the wavetable stack.
module mwi_store #(
    parameter int unsigned TABLE_BITS = mwi_pkg::TABLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic                                i_rd_en,
    input  logic [mwi_pkg::LEVEL_W-1:0]         i_level,
    input  logic [mwi_pkg::WIDX_W-1:0]          i_write_index,
    input  logic signed [mwi_pkg::SAMPLE_W-1:0] i_write_sample,
    input  logic [mwi_pkg::PHASE_W-1:0]         i_phase,
    output mwi_pkg::t_rd_data                   o_rd
);

    localparam int unsigned AW    = TABLE_BITS + 1;
    localparam int unsigned DEPTH = 2 ** AW;
    localparam int unsigned NB_W  = $clog2(TABLE_BITS + 1);
    localparam logic [mwi_pkg::LEVEL_W-1:0] TOP_LV = mwi_pkg::LEVEL_W'(TABLE_BITS - 1);
    localparam logic [AW:0] FULL = {1'b1, {AW{1'b0}}};

    logic [mwi_pkg::LEVEL_W-1:0]  lv;
    logic [NB_W-1:0]              nbits;
    logic [AW:0]                  span;
    logic [AW-1:0]                base;
    logic [TABLE_BITS-1:0]        mask;
    logic [TABLE_BITS-1:0]        idx_i;
    logic [TABLE_BITS-1:0]        idx_j;
    logic [TABLE_BITS-1:0]        wpos;
    logic [mwi_pkg::PHASE_W-1:0]  ph_sh;
    logic [AW-1:0]                addr_w;
    logic [AW-1:0]                addr_i;
    logic [AW-1:0]                addr_j;

    logic [mwi_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    mwi_pkg::t_rd_data            r_rd;

    // Clamp the level and locate its table inside the packed store
    always_comb begin
        lv     = (i_level > TOP_LV) ? TOP_LV : i_level;
        nbits  = NB_W'(TABLE_BITS) - NB_W'(lv);
        span   = (AW+1)'(2) << nbits;
        base   = AW'(FULL - span);
        mask   = {TABLE_BITS{1'b1}} >> lv;
        // Integer index from the top phase bits, fraction from the next 16
        idx_i  = i_phase[mwi_pkg::PHASE_W-1 -: TABLE_BITS] >> lv;
        idx_j  = (idx_i + TABLE_BITS'(1)) & mask;
        ph_sh  = i_phase << nbits;
        wpos   = TABLE_BITS'(i_write_index) & mask;
        addr_w = base + AW'(wpos);
        addr_i = base + AW'(idx_i);
        addr_j = base + AW'(idx_j);
    end

    // Write one sample; read the sample pair and hold it until the next read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[addr_w] <= i_write_sample;
        end
        if (i_rd_en) begin
            r_rd.si   <= r_mem[addr_i];
            r_rd.sj   <= r_mem[addr_j];
            r_rd.frac <= ph_sh[mwi_pkg::PHASE_W-1 -: mwi_pkg::FRAC_W];
        end
    end

    assign o_rd = r_rd;

endmodule

// ===== hdl/mwi_lerp.sv =====
// Pipelined linear interpolation with per-stage flow control.
module mwi_lerp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  mwi_pkg::t_rd_data                   i_rd,
    input  logic                                i_stall,
    output logic                                o_ready,
    output logic                                o_valid,
    output logic signed [mwi_pkg::SAMPLE_W-1:0] o_sample_out
);

    localparam int unsigned PROD_W = 2 * mwi_pkg::SAMPLE_W + 1;
    localparam int unsigned SUM_W  = mwi_pkg::SAMPLE_W + 2;

    logic                                en1;
    logic                                en2;
    logic                                en3;
    logic signed [mwi_pkg::SAMPLE_W:0]   diff;
    logic signed [mwi_pkg::FRAC_W:0]     fs;
    logic signed [PROD_W-1:0]            n_prod;
    logic signed [PROD_W-1:0]            rnd;
    logic signed [SUM_W-1:0]             sum;

    logic                                r_v1;
    logic                                r_v2;
    logic                                r_v3;
    logic signed [PROD_W-1:0]            r_prod;
    logic signed [mwi_pkg::SAMPLE_W-1:0] r_si2;
    logic signed [mwi_pkg::SAMPLE_W-1:0] r_out;

    // Advance a stage when the one after it is empty or moving
    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    // Scale the sample difference by the fraction
    always_comb begin
        diff   = (mwi_pkg::SAMPLE_W+1)'(i_rd.sj) - (mwi_pkg::SAMPLE_W+1)'(i_rd.si);
        fs     = $signed({1'b0, i_rd.frac});
        n_prod = PROD_W'(fs) * PROD_W'(diff);
        // Round to nearest with ties up, then add the base sample
        rnd    = (r_prod + PROD_W'(32768)) >>> mwi_pkg::FRAC_W;
        sum    = SUM_W'(r_si2) + $signed(rnd[SUM_W-1:0]);
    end

    // Track valid items through the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_load;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Hold product and result while their stage is stalled
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_prod <= n_prod;
            r_si2  <= i_rd.si;
        end
        if (en3) begin
            r_out <= sum[mwi_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_valid      = r_v3;
    assign o_sample_out = r_out;

    a_load_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready)
        else $error("read loaded while first stage blocked");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && i_stall) |-> !o_ready)
        else $error("full pipeline still accepting");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3))
        else $error("pipeline not empty after reset");

endmodule

// ===== hdl/mipmap_wavetable_interpolator_unit.sv =====
// A read item is registered in the store's read register, then the product register, then the output register.
// Throughput: one item per cycle while o_stall is low, write or read; the store's two read ports
// fetch both neighbor samples of a read in the same cycle.
// Write items give no result and take effect at the edge they are accepted.
// Reset clears the pipeline valid flags; table contents stay undefined
// until written, and no clearing pass runs.
module mipmap_wavetable_interpolator_unit #(
    parameter int unsigned TABLE_BITS = mwi_pkg::TABLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_func,
    input  logic [mwi_pkg::LEVEL_W-1:0]         i_level,
    input  logic [mwi_pkg::WIDX_W-1:0]          i_write_index,
    input  logic signed [mwi_pkg::SAMPLE_W-1:0] i_write_sample,
    input  logic [mwi_pkg::PHASE_W-1:0]         i_phase,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [mwi_pkg::SAMPLE_W-1:0] o_sample_out
);

    logic              ready;
    logic              acc;
    logic              wr_en;
    logic              rd_en;
    mwi_pkg::t_rd_data rd;

    // Accept an item whenever the first stage can take it
    assign o_stall = !ready;
    assign acc     = i_valid && ready;
    assign wr_en   = acc && (i_func == mwi_pkg::FUNC_WRITE);
    assign rd_en   = acc && (i_func == mwi_pkg::FUNC_READ);

    mwi_store #(
        .TABLE_BITS(TABLE_BITS)
    ) u_store (
        .i_clk         (i_clk),
        .i_wr_en       (wr_en),
        .i_rd_en       (rd_en),
        .i_level       (i_level),
        .i_write_index (i_write_index),
        .i_write_sample(i_write_sample),
        .i_phase       (i_phase),
        .o_rd          (rd)
    );

    mwi_lerp u_lerp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (rd_en),
        .i_rd        (rd),
        .i_stall     (i_stall),
        .o_ready     (ready),
        .o_valid     (o_valid),
        .o_sample_out(o_sample_out)
    );

endmodule
